// File: rtl/cpm_pkg.sv
// Package for the CIGAR parse-and-merge block: widths, character codes and
// the packed beat types of the input and result channels. No dependencies.
`default_nettype none

package cpm_pkg;

  // Width of an operation length; lengths saturate at all ones.
  localparam int LENGTH_BITS = 28;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  localparam logic [7:0] CH_ZERO = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE = 8'h39;  // '9'
  localparam logic [7:0] CH_EQ   = 8'h3D;  // '='
  localparam logic [7:0] CH_M    = 8'h4D;  // 'M'

  typedef struct packed {
    logic [7:0] char_in;
    logic       is_last;
  } cpm_in_t;

  typedef struct packed {
    logic [LENGTH_BITS-1:0] op_length;
    logic [7:0]             op_code;
    logic                   record_valid;
    logic                   run_end;
    logic                   bad_input;
  } cpm_out_t;

endpackage

`default_nettype wire

// File: rtl/cigar_parse_merge_core.sv
// Top level of the streaming CIGAR parser with run merging.
// Depends on cpm_pkg for the beat types, widths and character codes.
`default_nettype none

// The block reads CIGAR text one character per input beat and returns merged
// operation records (length, code) on the result channel. It accepts one
// character per clock cycle while the result buffer has room: all parsing for
// a character is combinational and its results land in a two-entry result
// buffer. A character makes zero, one or two results; two arise only when the
// final character of a string changes the operation code, and in that case
// the input holds off while the second result drains. in_ready depends
// combinationally on out_ready: a character is taken when the buffer will
// be empty after this cycle's output beat. Digits build a decimal length that
// saturates at the maximum of the length field; an operation code with no
// digits counts as length 0. Both cases, and merge overflow, set the sticky
// bad_input flag, which clears together with all parser state after the last
// character. '=' is reported as 'M', every other non-digit byte is taken as an
// operation code, and digits after the last code are dropped. An empty string
// yields a single result with record_valid low.
module cigar_parse_merge_core (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire cpm_pkg::cpm_in_t  in_data,
  output logic                   out_valid,
  input  wire                    out_ready,
  output cpm_pkg::cpm_out_t      out_data
);
  import cpm_pkg::*;

  // Parser state.
  logic [LENGTH_BITS-1:0] digit_accum_r, digit_accum_nxt;
  logic                   digits_seen_r, digits_seen_nxt;
  logic [LENGTH_BITS-1:0] held_length_r, held_length_nxt;
  logic [7:0]             held_code_r, held_code_nxt;
  logic                   held_valid_r, held_valid_nxt;
  logic                   error_r, error_nxt;

  // Result buffer: slot A drives the output, slot B holds a second result.
  logic     a_valid_r, a_valid_nxt;
  logic     b_valid_r, b_valid_nxt;
  cpm_out_t a_data_r, a_data_nxt;
  cpm_out_t b_data_r, b_data_nxt;

  logic in_acc;
  logic out_pop;

  logic                   is_digit;
  logic [3:0]             digit_val;
  logic [7:0]             code;
  logic [LENGTH_BITS+3:0] mac_sum;
  logic                   mac_ovf;
  logic [LENGTH_BITS-1:0] new_len;
  logic                   same_code;
  logic [LENGTH_BITS:0]   merge_sum;
  logic                   merge_ovf;
  logic                   emit_prev;
  logic                   emit_last;
  logic                   dig_err;
  logic                   upd_valid;
  logic [LENGTH_BITS-1:0] upd_length;
  logic [7:0]             upd_code;
  logic [LENGTH_BITS-1:0] upd_accum;
  logic                   upd_seen;
  cpm_out_t               prev_rec;
  cpm_out_t               last_rec;

  assign out_pop   = a_valid_r & out_ready;
  assign in_ready  = ~b_valid_r & (~a_valid_r | out_ready);
  assign in_acc    = in_valid & in_ready;
  assign out_valid = a_valid_r;
  assign out_data  = a_data_r;

  // Character decode and arithmetic.
  always_comb begin
    is_digit  = (in_data.char_in >= CH_ZERO) && (in_data.char_in <= CH_NINE);
    digit_val = 4'(in_data.char_in - CH_ZERO);
    code      = (in_data.char_in == CH_EQ) ? CH_M : in_data.char_in;

    // accum * 10 + digit, as two shifted adds; at most LENGTH_BITS + 4 bits.
    mac_sum = {1'b0, digit_accum_r, 3'b000} + {3'b000, digit_accum_r, 1'b0}
            + {{LENGTH_BITS{1'b0}}, digit_val};
    mac_ovf = |mac_sum[LENGTH_BITS+3:LENGTH_BITS];

    new_len   = digits_seen_r ? digit_accum_r : '0;
    dig_err   = ~is_digit & ~digits_seen_r;
    same_code = held_valid_r && (held_code_r == code);
    merge_sum = {1'b0, held_length_r} + {1'b0, new_len};
    merge_ovf = merge_sum[LENGTH_BITS];
    emit_prev = ~is_digit & held_valid_r & ~same_code;
    emit_last = in_data.is_last;

    error_nxt = error_r | dig_err | (is_digit & mac_ovf)
              | (~is_digit & same_code & merge_ovf);

    if (is_digit) begin
      upd_accum  = mac_ovf ? LEN_MAX : mac_sum[LENGTH_BITS-1:0];
      upd_seen   = 1'b1;
      upd_valid  = held_valid_r;
      upd_length = held_length_r;
      upd_code   = held_code_r;
    end else begin
      upd_accum = '0;
      upd_seen  = 1'b0;
      upd_valid = 1'b1;
      if (same_code) begin
        upd_length = merge_ovf ? LEN_MAX : merge_sum[LENGTH_BITS-1:0];
      end else begin
        upd_length = new_len;
      end
      upd_code = code;
    end

    prev_rec.op_length    = held_length_r;
    prev_rec.op_code      = held_code_r;
    prev_rec.record_valid = 1'b1;
    prev_rec.run_end      = 1'b0;
    prev_rec.bad_input    = error_nxt;

    last_rec.op_length    = upd_valid ? upd_length : '0;
    last_rec.op_code      = upd_valid ? upd_code : 8'h00;
    last_rec.record_valid = upd_valid;
    last_rec.run_end      = 1'b1;
    last_rec.bad_input    = error_nxt;
  end

  // Next parser state: the end of a string clears everything.
  always_comb begin
    digit_accum_nxt = digit_accum_r;
    digits_seen_nxt = digits_seen_r;
    held_length_nxt = held_length_r;
    held_code_nxt   = held_code_r;
    held_valid_nxt  = held_valid_r;
    if (in_acc) begin
      if (in_data.is_last) begin
        digit_accum_nxt = '0;
        digits_seen_nxt = 1'b0;
        held_length_nxt = '0;
        held_code_nxt   = 8'h00;
        held_valid_nxt  = 1'b0;
      end else begin
        digit_accum_nxt = upd_accum;
        digits_seen_nxt = upd_seen;
        held_length_nxt = upd_length;
        held_code_nxt   = upd_code;
        held_valid_nxt  = upd_valid;
      end
    end
  end

  // Result buffer update. A new character is only taken when both slots
  // will be free, so its results always start in slot A.
  always_comb begin
    a_valid_nxt = a_valid_r & ~out_pop;
    b_valid_nxt = b_valid_r;
    a_data_nxt  = a_data_r;
    b_data_nxt  = b_data_r;
    if (b_valid_r && out_pop) begin
      a_valid_nxt = 1'b1;
      a_data_nxt  = b_data_r;
      b_valid_nxt = 1'b0;
    end else if (in_acc) begin
      if (emit_prev) begin
        a_valid_nxt = 1'b1;
        a_data_nxt  = prev_rec;
        b_valid_nxt = emit_last;
        b_data_nxt  = last_rec;
      end else if (emit_last) begin
        a_valid_nxt = 1'b1;
        a_data_nxt  = last_rec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_accum_r <= '0;
      digits_seen_r <= 1'b0;
      held_length_r <= '0;
      held_code_r   <= 8'h00;
      held_valid_r  <= 1'b0;
      error_r       <= 1'b0;
      a_valid_r     <= 1'b0;
      b_valid_r     <= 1'b0;
    end else begin
      digit_accum_r <= digit_accum_nxt;
      digits_seen_r <= digits_seen_nxt;
      held_length_r <= held_length_nxt;
      held_code_r   <= held_code_nxt;
      held_valid_r  <= held_valid_nxt;
      if (in_acc) begin
        error_r <= in_data.is_last ? 1'b0 : error_nxt;
      end
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_data_r <= a_data_nxt;
    b_data_r <= b_data_nxt;
  end

  // The second slot is never filled while the output slot is empty.
  a_b_order: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r |-> a_valid_r)
    else $error("result slot B occupied with slot A empty");

  // When two results are buffered, the first closes a record and the second
  // ends the string.
  a_pair_shape: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r |-> (b_data_r.run_end && !a_data_r.run_end && a_data_r.record_valid))
    else $error("buffered result pair out of order");

  // A result that does not end a string always carries a record.
  a_mid_record: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.run_end) |-> out_data.record_valid)
    else $error("empty record emitted before end of string");

  // The last character of a string leaves the parser cleared.
  a_end_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.is_last) |=> (!held_valid_r && !digits_seen_r && !error_r))
    else $error("parser state not cleared after end of string");

  // Every accepted final character produces a result in the next cycle.
  a_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.is_last) |=> a_valid_r)
    else $error("end of string produced no result");

endmodule

`default_nettype wire
